[src/scp_pkg.sv]
// Shared constants and types for the segment collision points block.
// Used by every module of the block except scp_job_fifo; depends on nothing else.
package scp_pkg;

  // Default geometry of the coordinate and point formats.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int POINT_WIDTH     = 32;

  // Depth of the job queue between the front and back halves.
  localparam int JOB_QUEUE_DEPTH = 2;

  // Quotient bits the divider retires per cycle.
  localparam int DIV_BITS_PER_CYCLE = 2;

  // Bit positions of the endpoints in a collinear emit mask, in emit order.
  localparam int PT_B1 = 0;
  localparam int PT_B2 = 1;
  localparam int PT_A1 = 2;
  localparam int PT_A2 = 3;

  // Back half sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  // Control part of a job: crossing or collinear, and which endpoints to emit.
  typedef struct packed {
    logic       is_cross;
    logic [3:0] mask;
  } job_ctl_t;

endpackage

[src/scp_job_fifo.sv]
// Small register queue that carries jobs from the front half to the back half.
// Generic in width and depth; no package dependency.
module scp_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[src/scp_front.sv]
// Front half: accepts segment pairs, forms cross products and classifies each pair.
// Depends on scp_pkg for the job control type and endpoint mask positions.
module scp_front #(
  parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF,
  parameter int PW          = 3 * COORD_WIDTH + 5,
  parameter int XW          = 2 * COORD_WIDTH + 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
  output logic                          job_push,
  input  logic                          job_full,
  output scp_pkg::job_ctl_t             job_ctl,
  output logic [8*COORD_WIDTH+2*PW+XW-1:0] job_data
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;

  function automatic logic signed [XW-1:0] xp(input logic signed [DW-1:0] vx,
                                              input logic signed [DW-1:0] vy,
                                              input logic signed [DW-1:0] wx,
                                              input logic signed [DW-1:0] wy);
    return XW'(vx) * XW'(wy) - XW'(vy) * XW'(wx);
  endfunction

  function automatic logic in_span(input logic signed [W-1:0] v,
                                   input logic signed [W-1:0] p,
                                   input logic signed [W-1:0] q);
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic same_side(input logic signed [XW-1:0] s1,
                                     input logic signed [XW-1:0] s2);
    return (s1 != '0) && (s2 != '0) && (s1[XW-1] == s2[XW-1]);
  endfunction

  logic en;

  // Stage 1: endpoints and difference vectors.
  logic                v1;
  logic signed [W-1:0] c1 [8];
  logic signed [DW-1:0] dax1, day1, dbx1, dby1, w1x1, w1y1, w2x1, w2y1;
  logic signed [DW-1:0] u1x1, u1y1, u2x1, u2y1;

  // Stage 2: cross products.
  logic                v2;
  logic signed [W-1:0] c2 [8];
  logic signed [DW-1:0] dax2, day2;
  logic signed [XW-1:0] den2, d1_2, d2_2, e1_2, e2_2, num2;

  // Stage 3: classification.
  logic                v3;
  logic                keep3;
  logic signed [W-1:0] c3 [8];
  logic signed [DW-1:0] dax3, day3;
  logic signed [XW-1:0] den3, num3;
  scp_pkg::job_ctl_t   ctl3;

  // The whole front advances unless a kept job waits on a full queue.
  assign en       = !(v3 && keep3 && job_full);
  assign full     = !en;
  assign job_push = v3 && keep3 && !job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= seg_a_start_x;
      c1[1] <= seg_a_start_y;
      c1[2] <= seg_a_end_x;
      c1[3] <= seg_a_end_y;
      c1[4] <= seg_b_start_x;
      c1[5] <= seg_b_start_y;
      c1[6] <= seg_b_end_x;
      c1[7] <= seg_b_end_y;
      dax1  <= DW'(seg_a_end_x) - DW'(seg_a_start_x);
      day1  <= DW'(seg_a_end_y) - DW'(seg_a_start_y);
      dbx1  <= DW'(seg_b_end_x) - DW'(seg_b_start_x);
      dby1  <= DW'(seg_b_end_y) - DW'(seg_b_start_y);
      w1x1  <= DW'(seg_b_start_x) - DW'(seg_a_start_x);
      w1y1  <= DW'(seg_b_start_y) - DW'(seg_a_start_y);
      w2x1  <= DW'(seg_b_end_x) - DW'(seg_a_start_x);
      w2y1  <= DW'(seg_b_end_y) - DW'(seg_a_start_y);
      u1x1  <= DW'(seg_a_start_x) - DW'(seg_b_start_x);
      u1y1  <= DW'(seg_a_start_y) - DW'(seg_b_start_y);
      u2x1  <= DW'(seg_a_end_x) - DW'(seg_b_start_x);
      u2y1  <= DW'(seg_a_end_y) - DW'(seg_b_start_y);
    end
  end

  // Stage 2 registers: side tests, denominator and numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      c2   <= c1;
      dax2 <= dax1;
      day2 <= day1;
      den2 <= xp(dax1, day1, dbx1, dby1);
      d1_2 <= xp(dax1, day1, w1x1, w1y1);
      d2_2 <= xp(dax1, day1, w2x1, w2y1);
      e1_2 <= xp(dbx1, dby1, u1x1, u1y1);
      e2_2 <= xp(dbx1, dby1, u2x1, u2y1);
      num2 <= xp(w1x1, w1y1, dbx1, dby1);
    end
  end

  // Stage 3 classification logic.
  logic                collinear;
  logic                crossing;
  logic                onx;
  logic signed [W-1:0] va1, va2, vb1, vb2;
  logic                mb1, mb2;
  logic [3:0]          mask;

  always_comb begin
    collinear = (den2 == '0) && (d1_2 == '0);
    crossing  = !collinear && !same_side(d1_2, d2_2) && !same_side(e1_2, e2_2) &&
                (den2 != '0);
    onx       = (c2[0] != c2[2]);
    va1       = onx ? c2[0] : c2[1];
    va2       = onx ? c2[2] : c2[3];
    vb1       = onx ? c2[4] : c2[5];
    vb2       = onx ? c2[6] : c2[7];
    mb1       = in_span(vb1, va1, va2);
    mb2       = in_span(vb2, va1, va2);
    mask      = '0;
    mask[scp_pkg::PT_B1] = mb1;
    mask[scp_pkg::PT_B2] = mb2;
    // A's endpoints count only when B gave fewer than two points.
    if (!(mb1 && mb2)) begin
      mask[scp_pkg::PT_A1] = in_span(va1, vb1, vb2);
      mask[scp_pkg::PT_A2] = in_span(va2, vb1, vb2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3            <= c2;
      dax3          <= dax2;
      day3          <= day2;
      ctl3.is_cross <= crossing;
      ctl3.mask     <= collinear ? mask : 4'b0000;
      keep3         <= collinear ? (mask != 4'b0000) : crossing;
      // Normalize to a positive denominator.
      den3          <= den2[XW-1] ? -den2 : den2;
      num3          <= den2[XW-1] ? -num2 : num2;
    end
  end

  // Job assembly; the queue entry registers the numerator products.
  logic signed [PW-1:0] px3, py3;

  assign px3     = PW'(num3) * PW'(dax3);
  assign py3     = PW'(num3) * PW'(day3);
  assign job_ctl = ctl3;
  assign job_data = {c3[0], c3[1], c3[2], c3[3], c3[4], c3[5], c3[6], c3[7],
                     px3, py3, den3};

endmodule

[src/scp_divider.sv]
// Floor divider of a signed numerator by a positive denominator, a few bits a cycle.
// Depends on scp_pkg for the bits retired per cycle.
module scp_divider #(
  parameter int PW = 53,
  parameter int XW = 36,
  parameter int QB = 34,
  parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [PW-1:0] num,
  input  logic [XW-1:0]        den,
  output logic                 done,
  output logic signed [QB:0]   quot
);

  localparam int S  = scp_pkg::DIV_BITS_PER_CYCLE;
  localparam int N  = QB / S;
  localparam int RW = XW + 1;
  localparam int DV = PW + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [RW-1:0] rem;
  logic [QB-1:0] dvd;
  logic [XW-1:0] den_r;

  logic [PW-1:0] mag;
  logic [DV-1:0] dividend;
  logic [RW-1:0] rem_step;
  logic [QB-1:0] dvd_step;

  // Scaled magnitude; its upper part is already below the denominator.
  assign mag      = num[PW-1] ? PW'(-num) : PW'(num);
  assign dividend = DV'(mag) << FRAC_BITS;
  assign done     = busy && (cnt == CW'(N - 1));

  // Restoring steps for one cycle.
  always_comb begin
    rem_step = rem;
    dvd_step = dvd;
    for (int i = 0; i < S; i++) begin
      rem_step = {rem_step[RW-2:0], dvd_step[QB-1]};
      dvd_step = {dvd_step[QB-2:0], 1'b0};
      if (rem_step >= RW'(den_r)) begin
        rem_step    = rem_step - RW'(den_r);
        dvd_step[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[PW-1];
      den_r <= den;
      rem   <= RW'(dividend >> QB);
      dvd   <= dividend[QB-1:0];
    end else if (busy) begin
      rem <= rem_step;
      dvd <= dvd_step;
    end
  end

  // Floor toward minus infinity for a negative numerator.
  assign quot = neg ? -((QB+1)'(dvd) + (QB+1)'(rem != '0)) : (QB+1)'(dvd);

endmodule

[src/scp_back.sv]
// Back half: takes jobs from the queue, divides crossings and emits the points.
// Depends on scp_pkg and instantiates scp_divider twice.
module scp_back #(
  parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = scp_pkg::FRAC_BITS_DEF,
  parameter int PW          = 3 * COORD_WIDTH + 5,
  parameter int XW          = 2 * COORD_WIDTH + 4,
  parameter int QB          = 34
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   job_valid,
  input  scp_pkg::job_ctl_t                      job_ctl,
  input  logic [8*COORD_WIDTH+2*PW+XW-1:0]       job_data,
  output logic                                   job_pop,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [scp_pkg::POINT_WIDTH-1:0] point_x,
  output logic signed [scp_pkg::POINT_WIDTH-1:0] point_y,
  output logic                                   from_endpoint,
  output logic                                   last_point
);

  localparam int W  = COORD_WIDTH;
  localparam int OW = scp_pkg::POINT_WIDTH;

  scp_pkg::back_state_t state, state_next;

  logic signed [W-1:0] c [8];
  logic signed [W-1:0] jc [8];
  logic signed [PW-1:0] jpx, jpy;
  logic [XW-1:0]       jden;
  logic                is_cross;
  logic [3:0]          mask;
  logic                out_valid;
  logic                out_free;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic signed [QB:0]  qx, qy;
  logic [3:0]          sel;
  logic                last;
  logic signed [W-1:0] ex, ey;

  assign {jc[0], jc[1], jc[2], jc[3], jc[4], jc[5], jc[6], jc[7], jpx, jpy, jden} = job_data;

  scp_divider #(.PW(PW), .XW(XW), .QB(QB), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(jpx), .den(jden),
    .done(div_done), .quot(qx)
  );

  scp_divider #(.PW(PW), .XW(XW), .QB(QB), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(jpy), .den(jden),
    .done(), .quot(qy)
  );

  // Lowest pending endpoint goes out first.
  assign sel      = mask & (~mask + 4'd1);
  assign last     = is_cross || ((mask & ~sel) == 4'b0000);
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_comb begin
    ex = c[6];
    ey = c[7];
    if (sel[scp_pkg::PT_B1]) begin
      ex = c[4];
      ey = c[5];
    end else if (sel[scp_pkg::PT_B2]) begin
      ex = c[6];
      ey = c[7];
    end else if (sel[scp_pkg::PT_A1]) begin
      ex = c[0];
      ey = c[1];
    end else if (sel[scp_pkg::PT_A2]) begin
      ex = c[2];
      ey = c[3];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      scp_pkg::BK_IDLE: begin
        if (job_valid) state_next = job_ctl.is_cross ? scp_pkg::BK_DIV : scp_pkg::BK_EMIT;
      end
      scp_pkg::BK_DIV: begin
        if (div_done) state_next = scp_pkg::BK_EMIT;
      end
      scp_pkg::BK_EMIT: begin
        if (out_free && last) state_next = scp_pkg::BK_IDLE;
      end
      default: state_next = scp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    job_pop   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      scp_pkg::BK_IDLE: begin
        job_pop   = job_valid;
        div_start = job_valid && job_ctl.is_cross;
      end
      scp_pkg::BK_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scp_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Job and result word registers.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      c        <= jc;
      is_cross <= job_ctl.is_cross;
      mask     <= job_ctl.mask;
    end else if (out_load && !is_cross) begin
      mask <= mask & ~sel;
    end
    if (out_load) begin
      if (is_cross) begin
        point_x       <= (OW'(c[0]) << FRAC_BITS) + OW'(qx);
        point_y       <= (OW'(c[1]) << FRAC_BITS) + OW'(qy);
        from_endpoint <= 1'b0;
      end else begin
        point_x       <= OW'(ex) << FRAC_BITS;
        point_y       <= OW'(ey) << FRAC_BITS;
        from_endpoint <= 1'b1;
      end
      last_point <= last;
    end
  end

endmodule

[src/segment_collision_points.sv]
// Contact points of two 2D line segments, top level.
// Depends on scp_pkg and instantiates scp_front, scp_job_fifo and scp_back.
//
// Usage: push a segment pair (A start/end, B start/end, signed integers) while
// full is low. Each pair yields zero to three words on the result side, Q16.16
// points in order, the final one with last_point set; a crossing yields one
// word with from_endpoint low, a collinear overlap yields copied endpoints.
// Pairs that do not touch yield nothing. Read a word while empty is low by
// raising pop.
// An accepted pair passes the front's stages (differences, cross products,
// classification) into the job queue, and the back half takes it from there
// when idle. A collinear pair then loads one word a cycle while the output
// word is free; a crossing first waits while the two radix-4 dividers, one
// per coordinate, run side by side. The front accepts one pair a cycle while
// full is low; the sustained rate is that of the back half.
// When the reader stalls, the output word holds, the back half waits, the
// two-entry job queue fills and then full rises. Reset empties the pipeline,
// the queue and the output word.
module segment_collision_points #(
  parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = scp_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = scp_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_start_x,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_start_y,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_end_x,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_end_y,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_start_x,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_start_y,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_end_x,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_end_y,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [scp_pkg::POINT_WIDTH-1:0] point_x,
  output logic signed [scp_pkg::POINT_WIDTH-1:0] point_y,
  output logic                                   from_endpoint,
  output logic                                   last_point
);

  localparam int XW  = 2 * COORD_WIDTH + 4;
  localparam int PW  = XW + COORD_WIDTH + 1;
  localparam int S   = scp_pkg::DIV_BITS_PER_CYCLE;
  localparam int QB  = ((COORD_WIDTH + FRAC_BITS + 2 + S - 1) / S) * S;
  localparam int JDW = 8 * COORD_WIDTH + 2 * PW + XW;
  localparam int CTW = $bits(scp_pkg::job_ctl_t);

  logic              job_push;
  logic              job_full;
  logic              job_empty;
  logic              job_pop;
  scp_pkg::job_ctl_t push_ctl;
  scp_pkg::job_ctl_t head_ctl;
  logic [JDW-1:0]    push_data;
  logic [JDW-1:0]    head_data;

  scp_front #(.COORD_WIDTH(COORD_WIDTH), .PW(PW), .XW(XW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .seg_a_start_x(seg_a_start_x), .seg_a_start_y(seg_a_start_y),
    .seg_a_end_x(seg_a_end_x), .seg_a_end_y(seg_a_end_y),
    .seg_b_start_x(seg_b_start_x), .seg_b_start_y(seg_b_start_y),
    .seg_b_end_x(seg_b_end_x), .seg_b_end_y(seg_b_end_y),
    .job_push(job_push), .job_full(job_full), .job_ctl(push_ctl), .job_data(push_data)
  );

  scp_job_fifo #(.WIDTH(CTW + JDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(job_push), .push_data({push_ctl, push_data}), .full(job_full),
    .pop(job_pop), .pop_data({head_ctl, head_data}), .empty(job_empty)
  );

  scp_back #(
    .COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .PW(PW), .XW(XW), .QB(QB)
  ) u_back (
    .clk(clk), .rst(rst),
    .job_valid(!job_empty), .job_ctl(head_ctl), .job_data(head_data), .job_pop(job_pop),
    .pop(pop), .empty(empty),
    .point_x(point_x), .point_y(point_y),
    .from_endpoint(from_endpoint), .last_point(last_point)
  );

  // The front never hands a job to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(job_push && job_full))
    else $error("job pushed into a full queue");

  // A computed crossing is always the only, hence last, point of its pair.
  a_cross_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !from_endpoint) |-> last_point)
    else $error("crossing point not marked last");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // The back half takes a job only when one is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) job_pop |-> !job_empty)
    else $error("job taken from an empty queue");

endmodule

[bench/scp_checker.sv]
// Checker for segment_collision_points: watches the push and pop channels,
// predicts contact points from each accepted pair and compares each popped word.
// Depends on the block's port widths only.
`timescale 1ns / 1ps

module scp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               from_endpoint,
  input  logic               last_point,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        endp;
    logic        last;
  } point_word_t;

  point_word_t expected_points[$];

  function automatic longint cross2(longint vx, longint vy, longint wx, longint wy);
    return vx * wy - vy * wx;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic bit between(longint v, longint p, longint q);
    longint lo, hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return v >= lo && v <= hi;
  endfunction

  // Floor of base + p/den in Q16.16, den positive.
  function automatic longint floor_fix(longint base, longint p, longint den);
    longint q, r;
    q = p / den;
    r = p % den;
    if (r < 0) begin
      q -= 1;
      r += den;
    end
    return (base + q) * 65536 + (r * 65536) / den;
  endfunction

  function automatic point_word_t endpoint_word(longint x, longint y);
    point_word_t w;
    w.x = 32'(x * 65536);
    w.y = 32'(y * 65536);
    w.endp = 1'b1;
    w.last = 1'b0;
    return w;
  endfunction

  // Compute the contact points of one pair and queue them in emit order.
  task automatic predict_contacts(longint ax1, longint ay1, longint ax2, longint ay2,
                                  longint bx1, longint by1, longint bx2, longint by2);
    point_word_t found[$];
    point_word_t w;
    longint dax, day, dbx, dby, d1, d2, e1, e2, num, den;
    longint va1, va2, vb1, vb2;
    bit onx;
    dax = ax2 - ax1; day = ay2 - ay1;
    dbx = bx2 - bx1; dby = by2 - by1;
    if (cross2(dax, day, dbx, dby) == 0 && cross2(dax, day, bx1 - ax1, by1 - ay1) == 0) begin
      onx = (ax1 != ax2);
      va1 = onx ? ax1 : ay1; va2 = onx ? ax2 : ay2;
      vb1 = onx ? bx1 : by1; vb2 = onx ? bx2 : by2;
      if (between(vb1, va1, va2)) found = {found, endpoint_word(bx1, by1)};
      if (between(vb2, va1, va2)) found = {found, endpoint_word(bx2, by2)};
      if (found.size() < 2) begin
        if (between(va1, vb1, vb2)) found = {found, endpoint_word(ax1, ay1)};
        if (between(va2, vb1, vb2)) found = {found, endpoint_word(ax2, ay2)};
      end
    end else begin
      d1 = cross2(dax, day, bx1 - ax1, by1 - ay1);
      d2 = cross2(dax, day, bx2 - ax1, by2 - ay1);
      e1 = cross2(dbx, dby, ax1 - bx1, ay1 - by1);
      e2 = cross2(dbx, dby, ax2 - bx1, ay2 - by1);
      num = cross2(bx1 - ax1, by1 - ay1, dbx, dby);
      den = cross2(dax, day, dbx, dby);
      if (!(sign_of(d1) * sign_of(d2) > 0 || sign_of(e1) * sign_of(e2) > 0) && den != 0) begin
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        w.x = 32'(floor_fix(ax1, num * dax, den));
        w.y = 32'(floor_fix(ay1, num * day, den));
        w.endp = 1'b0;
        w.last = 1'b0;
        found = {found, w};
      end
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) expected_points = {expected_points, found[i]};
  endtask

  assign pending = expected_points.size();

  // Predict on every accepted pair, compare every accepted word.
  always @(posedge clk) begin
    point_word_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (push && !full)
        predict_contacts(a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y);
      if (pop && !empty) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h endp=%b last=%b", $time,
                   point_x, point_y, from_endpoint, last_point);
          errors <= errors + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== point_x || want.y !== point_y ||
              want.endp !== from_endpoint || want.last !== last_point) begin
            $display("%0t: expected x=%h y=%h endp=%b last=%b, got x=%h y=%h endp=%b last=%b",
                     $time, want.x, want.y, want.endp, want.last,
                     point_x, point_y, from_endpoint, last_point);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[bench/tb.sv]
// Testbench top for segment_collision_points: drives segment pairs with
// random gaps, pops words with random stalls, and reports the verdict.
// Depends on scp_checker and the block itself.
`timescale 1ns / 1ps

module tb;

  logic clk;
  logic rst;
  logic push, pop;
  logic full, empty;
  logic signed [15:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  logic signed [31:0] point_x, point_y;
  logic from_endpoint, last_point;
  int errors, pending;
  bit stimulus_done;

  segment_collision_points dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .seg_a_start_x(a1x), .seg_a_start_y(a1y), .seg_a_end_x(a2x), .seg_a_end_y(a2y),
    .seg_b_start_x(b1x), .seg_b_start_y(b1y), .seg_b_end_x(b2x), .seg_b_end_y(b2y),
    .empty(empty), .pop(pop), .point_x(point_x), .point_y(point_y),
    .from_endpoint(from_endpoint), .last_point(last_point)
  );

  scp_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a1x(a1x), .a1y(a1y), .a2x(a2x), .a2y(a2y),
    .b1x(b1x), .b1y(b1y), .b2x(b2x), .b2y(b2y),
    .empty(empty), .pop(pop), .point_x(point_x), .point_y(point_y),
    .from_endpoint(from_endpoint), .last_point(last_point),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random coordinate: small half the time so that segments meet, else full range or an extreme.
  function automatic logic [15:0] coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Present one pair after a random gap and hold it until accepted; push stays
  // high afterwards so that a pair with no gap follows directly.
  task automatic send_pair(logic [15:0] p0, p1, p2, p3, p4, p5, p6, p7);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    {a1x, a1y, a2x, a2y} <= {p0, p1, p2, p3};
    {b1x, b1y, b2x, b2y} <= {p4, p5, p6, p7};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Pair shaped to hit collinear overlaps, crossings or random geometry.
  task automatic send_random_pair();
    logic signed [15:0] x0, y0, dx, dy;
    int s0, s1, s2, s3;
    case ($urandom_range(0, 3))
      0: begin
        x0 = coord(); y0 = coord();
        dx = 16'($signed($urandom_range(0, 6)) - 3);
        dy = 16'($signed($urandom_range(0, 6)) - 3);
        s0 = $signed($urandom_range(0, 8)) - 4; s1 = $signed($urandom_range(0, 8)) - 4;
        s2 = $signed($urandom_range(0, 8)) - 4; s3 = $signed($urandom_range(0, 8)) - 4;
        send_pair(16'(x0 + s0 * dx), 16'(y0 + s0 * dy), 16'(x0 + s1 * dx),
                  16'(y0 + s1 * dy), 16'(x0 + s2 * dx), 16'(y0 + s2 * dy),
                  16'(x0 + s3 * dx), 16'(y0 + s3 * dy));
      end
      1: begin
        x0 = coord(); y0 = coord();
        send_pair(x0 - 16'($urandom_range(0, 500)), y0 - 16'($urandom_range(0, 500)),
                  x0 + 16'($urandom_range(0, 500)), y0 + 16'($urandom_range(0, 500)),
                  x0 - 16'($urandom_range(0, 500)), y0 + 16'($urandom_range(0, 500)),
                  x0 + 16'($urandom_range(0, 500)), y0 - 16'($urandom_range(0, 500)));
      end
      default:
        send_pair(coord(), coord(), coord(), coord(), coord(), coord(), coord(), coord());
    endcase
  endtask

  // Stimulus: directed corner cases, then random pairs.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    {a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Plain crossing, then touching at an endpoint.
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(0, 0, 10, 0, 5, 0, 5, 7);
    // Crossing with a fractional point.
    send_pair(0, 0, 3, 1, 0, 1, 1, -2);
    // Collinear overlaps on x, and on y for a vertical A.
    send_pair(0, 0, 10, 0, 2, 0, 5, 0);
    send_pair(0, 0, 10, 0, -5, 0, 20, 0);
    send_pair(0, 0, 10, 0, 5, 0, 20, 0);
    send_pair(3, 0, 3, 10, 3, 12, 3, -4);
    send_pair(3, 0, 3, 10, 3, 4, 3, 40);
    // Parallel apart, disjoint collinear, no contact.
    send_pair(0, 0, 10, 0, 0, 1, 10, 1);
    send_pair(0, 0, 10, 0, 20, 0, 30, 0);
    send_pair(0, 0, 10, 10, 20, 0, 30, 5);
    // Degenerate segments: A a single point, B a single point.
    send_pair(4, 4, 4, 4, 4, 0, 4, 9);
    send_pair(4, 4, 4, 4, 4, 4, 4, 4);
    send_pair(0, 0, 10, 10, 5, 5, 5, 5);
    send_pair(0, 0, 10, 10, 5, 6, 5, 6);
    // Extreme coordinates.
    send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    send_pair(16'hffff, 16'h7fff, 16'hffff, 16'h8000, 16'h8000, 16'h0001, 16'h7fff, 16'hfffe);
    repeat (320) send_random_pair();
    push <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Reader: random stalls per word, with calm stretches.
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Verdict once everything has drained.
  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("segment_collision_points: match");
    else
      $display("segment_collision_points: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("segment_collision_points: mismatch");
    $finish;
  end

endmodule

[filelist.f]
src/scp_pkg.sv
src/scp_job_fifo.sv
src/scp_front.sv
src/scp_divider.sv
src/scp_back.sv
src/segment_collision_points.sv
bench/scp_checker.sv
bench/tb.sv
